// File: hdl/pvq_pkg.sv
// Shared types, constants and distance function for the palette vector quantizer.
package pvq_pkg;

  localparam int unsigned ChanW      = 5;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned NumEntries = 16;
  localparam int unsigned EntriesPerReg = 4;
  localparam int unsigned NumPalRegs = 4;
  localparam int unsigned RegIdxW    = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned EntryW     = 15;
  localparam int unsigned CfgW       = 60;
  localparam int unsigned DistW      = 12;
  localparam int unsigned OutW       = 8;

  // largest possible distance is 3 * 31^2 = 2883
  localparam logic [DistW-1:0] MaxDist  = 12'd2883;
  localparam logic [DistW-1:0] DistInit = '1;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [DistW-1:0] dist_t;

  // red in the low bits, blue in the high bits
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // word handed from cell to cell
  typedef struct packed {
    pixel_t even_pix;
    pixel_t odd_pix;
    dist_t  even_dist;
    dist_t  odd_dist;
    idx_t   even_idx;
    idx_t   odd_idx;
  } word_t;

  function automatic logic [2*ChanW-1:0] sq_diff(chan_t a, chan_t b);
    chan_t d;
    d = (a >= b) ? chan_t'(a - b) : chan_t'(b - a);
    return d * d;
  endfunction

  function automatic dist_t distance(pixel_t p, pixel_t e);
    return dist_t'(sq_diff(p.red, e.red)) + dist_t'(sq_diff(p.green, e.green))
         + dist_t'(sq_diff(p.blue, e.blue));
  endfunction

endpackage

// File: hdl/pvq_if.sv
// Valid/ready stream interfaces for pixel pair input and packed index output.
interface pvq_in_if;
  logic                valid;
  logic                ready;
  pvq_pkg::chan_t      even_red;
  pvq_pkg::chan_t      even_green;
  pvq_pkg::chan_t      even_blue;
  pvq_pkg::chan_t      odd_red;
  pvq_pkg::chan_t      odd_green;
  pvq_pkg::chan_t      odd_blue;

  modport source (output valid, even_red, even_green, even_blue,
                  odd_red, odd_green, odd_blue, input ready);
  modport sink   (input valid, even_red, even_green, even_blue,
                  odd_red, odd_green, odd_blue, output ready);
endinterface

interface pvq_out_if;
  logic                         valid;
  logic                         ready;
  logic [pvq_pkg::OutW-1:0]     packed_indices;

  modport source (output valid, packed_indices, input ready);
  modport sink   (input valid, packed_indices, output ready);
endinterface

// File: hdl/pvq_cell.sv
// One chain cell: compares both pixels against one palette entry and keeps the nearer match.
module pvq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvq_pkg::pixel_t    entry_i,
  input  pvq_pkg::idx_t      entry_idx_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pvq_pkg::word_t     in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pvq_pkg::word_t     out_word_o
);

  logic           valid_q;
  pvq_pkg::word_t word_q, word_d;
  pvq_pkg::dist_t even_dist, odd_dist;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_comb begin
    even_dist = pvq_pkg::distance(in_word_i.even_pix, entry_i);
    odd_dist  = pvq_pkg::distance(in_word_i.odd_pix, entry_i);
    word_d    = in_word_i;
    // strict compare: lower index keeps ties
    if (even_dist < in_word_i.even_dist) begin
      word_d.even_dist = even_dist;
      word_d.even_idx  = entry_idx_i;
    end
    if (odd_dist < in_word_i.odd_dist) begin
      word_d.odd_dist = odd_dist;
      word_d.odd_idx  = entry_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

endmodule

// File: hdl/palette_vector_quantizer.sv
// Top level of the palette vector quantizer: palette registers and the chain of 16 cells.
// Each accepted pixel pair walks a chain of 16 cells, one per palette entry, through the
// register of each cell in order; one pair enters and one result leaves every
// cycle while the output side keeps up. Every cell holds one word and stalls on its own,
// so a held result only blocks the cells behind it and empty cells keep filling. Each pixel
// gets the index of the nearest palette color by squared RGB distance, lowest index on a
// tie; odd pixel in bits 7:4, even pixel in bits 3:0. Palette registers 0 to 3 hold four
// 15-bit entries each (red 4:0, green 9:5, blue 14:10, lowest entry in the low bits) and
// reset to black; writes to other indexes are dropped. Write the palette only while the
// chain is empty.
module palette_vector_quantizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pvq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pvq_pkg::CfgW-1:0]      cfg_wdata_i,
  pvq_in_if.sink                        in_i,
  pvq_out_if.source                     out_o
);

  logic [pvq_pkg::CfgW-1:0] pal_q [pvq_pkg::NumPalRegs];

  logic           vld   [pvq_pkg::NumEntries+1];
  logic           rdy   [pvq_pkg::NumEntries+1];
  pvq_pkg::word_t word  [pvq_pkg::NumEntries+1];
  pvq_pkg::pixel_t entry [pvq_pkg::NumEntries];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pvq_pkg::NumPalRegs; i++) begin
        pal_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_index_i < pvq_pkg::CfgIdxW'(pvq_pkg::NumPalRegs))) begin
      pal_q[cfg_index_i[pvq_pkg::RegIdxW-1:0]] <= cfg_wdata_i;
    end
  end

  assign word[0] = '{
    even_pix:  '{blue: in_i.even_blue, green: in_i.even_green, red: in_i.even_red},
    odd_pix:   '{blue: in_i.odd_blue, green: in_i.odd_green, red: in_i.odd_red},
    even_dist: pvq_pkg::DistInit,
    odd_dist:  pvq_pkg::DistInit,
    even_idx:  '0,
    odd_idx:   '0
  };

  assign vld[0]     = in_i.valid;
  assign in_i.ready = rdy[0];

  for (genvar k = 0; k < pvq_pkg::NumEntries; k++) begin : g_cell
    assign entry[k] = pvq_pkg::pixel_t'(
      pal_q[k / pvq_pkg::EntriesPerReg]
           [(k % pvq_pkg::EntriesPerReg) * pvq_pkg::EntryW +: pvq_pkg::EntryW]);

    pvq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .entry_i     (entry[k]),
      .entry_idx_i (pvq_pkg::idx_t'(k)),
      .in_valid_i  (vld[k]),
      .in_ready_o  (rdy[k]),
      .in_word_i   (word[k]),
      .out_valid_o (vld[k+1]),
      .out_ready_i (rdy[k+1]),
      .out_word_o  (word[k+1])
    );
  end

  assign out_o.valid          = vld[pvq_pkg::NumEntries];
  assign rdy[pvq_pkg::NumEntries] = out_o.ready;
  assign out_o.packed_indices = {word[pvq_pkg::NumEntries].odd_idx,
                                 word[pvq_pkg::NumEntries].even_idx};

  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (word[pvq_pkg::NumEntries].even_dist <= pvq_pkg::MaxDist) &&
                    (word[pvq_pkg::NumEntries].odd_dist <= pvq_pkg::MaxDist))
    else $error("result left the chain without a palette match");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld[1])
    else $error("accepted pair did not land in the first cell");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld[1] |-> in_i.ready)
    else $error("empty first cell refused input");

endmodule

// File: tb/palette_vector_quantizer_tb.sv
// Testbench for palette_vector_quantizer: directed and random pixel pairs checked against a predictor.
module palette_vector_quantizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pvq_pkg::CfgIdxW-1:0] PalReg0           = 3'd0;
  localparam logic [pvq_pkg::CfgIdxW-1:0] PalReg1           = 3'd1;
  localparam logic [pvq_pkg::CfgIdxW-1:0] PalReg2           = 3'd2;
  localparam logic [pvq_pkg::CfgIdxW-1:0] PalReg3           = 3'd3;
  localparam logic [pvq_pkg::CfgIdxW-1:0] PalRegFirstUnused = 3'd4;
  localparam logic [pvq_pkg::CfgIdxW-1:0] PalRegLastUnused  = 3'd7;

  localparam int DrainCycles  = 24;
  localparam int IdleLimit    = 2000;
  localparam int MaxPrinted   = 40;
  localparam int PhaseItems   = 170;
  localparam int NumPhases    = 6;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [pvq_pkg::CfgIdxW-1:0]     cfg_index_i;
  logic [pvq_pkg::CfgW-1:0]        cfg_wdata_i;

  pvq_in_if  pix_if ();
  pvq_out_if idx_if ();

  palette_vector_quantizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (pix_if),
    .out_o       (idx_if)
  );

  pvq_pkg::pixel_t          pal_model [pvq_pkg::NumEntries];
  pvq_pkg::pixel_t          pal_next  [pvq_pkg::NumEntries];
  logic [pvq_pkg::OutW-1:0] expected_indices_q [$];
  int                       mismatches;
  int                       idle_cycles;
  int                       out_stall;
  bit                       no_gaps;

  always #1 clk_i = ~clk_i;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pvq_pkg::idx_t nearest_entry(pvq_pkg::pixel_t p);
    pvq_pkg::idx_t best;
    int   best_sq;
    int   dr, dg, db, sq;
    best    = '0;
    best_sq = 32'h7fffffff;
    for (int k = 0; k < pvq_pkg::NumEntries; k++) begin
      dr = int'(p.red) - int'(pal_model[k].red);
      dg = int'(p.green) - int'(pal_model[k].green);
      db = int'(p.blue) - int'(pal_model[k].blue);
      sq = dr * dr + dg * dg + db * db;
      if (sq < best_sq) begin
        best_sq = sq;
        best    = pvq_pkg::idx_t'(k);
      end
    end
    return best;
  endfunction

  function automatic pvq_pkg::pixel_t make_pixel(int r, int g, int b);
    pvq_pkg::pixel_t p;
    p.red   = pvq_pkg::chan_t'(r);
    p.green = pvq_pkg::chan_t'(g);
    p.blue  = pvq_pkg::chan_t'(b);
    return p;
  endfunction

  function automatic pvq_pkg::chan_t nudge(pvq_pkg::chan_t c);
    int v;
    v = int'(c) + $urandom_range(0, 4) - 2;
    if (v < 0) v = 0;
    if (v > 31) v = 31;
    return pvq_pkg::chan_t'(v);
  endfunction

  function automatic pvq_pkg::chan_t coarse_level();
    case ($urandom_range(0, 3))
      0: return pvq_pkg::chan_t'(0);
      1: return pvq_pkg::chan_t'(15);
      2: return pvq_pkg::chan_t'(16);
      default: return pvq_pkg::chan_t'(31);
    endcase
  endfunction

  function automatic pvq_pkg::pixel_t random_pixel();
    pvq_pkg::pixel_t p;
    int     r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      p = pvq_pkg::pixel_t'($urandom());
    end else if (r < 65) begin
      p = pal_model[$urandom_range(0, pvq_pkg::NumEntries - 1)];
    end else if (r < 85) begin
      p       = pal_model[$urandom_range(0, pvq_pkg::NumEntries - 1)];
      p.red   = nudge(p.red);
      p.green = nudge(p.green);
      p.blue  = nudge(p.blue);
    end else begin
      p.red   = $urandom_range(0, 1) ? pvq_pkg::chan_t'(31) : pvq_pkg::chan_t'(0);
      p.green = $urandom_range(0, 1) ? pvq_pkg::chan_t'(31) : pvq_pkg::chan_t'(0);
      p.blue  = $urandom_range(0, 1) ? pvq_pkg::chan_t'(31) : pvq_pkg::chan_t'(0);
    end
    return p;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MaxPrinted) $display("%0t ns: %s", $realtime, msg);
  endtask

  task automatic write_reg(logic [pvq_pkg::CfgIdxW-1:0] idx, logic [pvq_pkg::CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= PalReg3) begin
      for (int k = 0; k < pvq_pkg::EntriesPerReg; k++)
        pal_model[int'(idx) * pvq_pkg::EntriesPerReg + k] =
          pvq_pkg::pixel_t'(data[k*pvq_pkg::EntryW +: pvq_pkg::EntryW]);
    end
    @(posedge clk_i);
  endtask

  task automatic load_palette();
    logic [pvq_pkg::CfgW-1:0] data;
    for (int i = 0; i < pvq_pkg::NumPalRegs; i++) begin
      data = {pal_next[4*i+3], pal_next[4*i+2], pal_next[4*i+1], pal_next[4*i]};
      write_reg(PalReg0 + pvq_pkg::CfgIdxW'(i), data);
    end
  endtask

  task automatic send_pair(pvq_pkg::pixel_t even_pix, pvq_pkg::pixel_t odd_pix);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid      <= 1'b1;
    pix_if.even_red   <= even_pix.red;
    pix_if.even_green <= even_pix.green;
    pix_if.even_blue  <= even_pix.blue;
    pix_if.odd_red    <= odd_pix.red;
    pix_if.odd_green  <= odd_pix.green;
    pix_if.odd_blue   <= odd_pix.blue;
    do @(posedge clk_i); while (!pix_if.ready);
    expected_indices_q.push_back({nearest_entry(odd_pix), nearest_entry(even_pix)});
  endtask

  // stop sending and let the chain empty before touching the palette
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    while (expected_indices_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_reset_palette();
    send_pair(make_pixel(0, 0, 0), make_pixel(31, 31, 31));
    send_pair(make_pixel(31, 0, 31), make_pixel(0, 31, 0));
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(PalReg0, '1);
    write_reg(PalReg1, '1);
    write_reg(PalReg2, '1);
    write_reg(PalReg3, '1);
    send_pair(make_pixel(0, 0, 0), make_pixel(31, 31, 31));
    send_pair(make_pixel(31, 31, 31), make_pixel(5, 17, 29));
    wait_idle();
    write_reg(PalReg0, '0);
    write_reg(PalReg1, '0);
    write_reg(PalReg2, '0);
    write_reg(PalReg3, '0);
    send_pair(make_pixel(31, 31, 31), make_pixel(1, 0, 0));
    wait_idle();
  endtask

  task automatic test_ties_and_duplicates();
    pal_next[0]  = make_pixel(0, 0, 0);
    pal_next[1]  = make_pixel(2, 0, 0);
    pal_next[2]  = make_pixel(31, 31, 31);
    pal_next[3]  = make_pixel(0, 31, 0);
    pal_next[4]  = make_pixel(31, 0, 0);
    pal_next[5]  = make_pixel(0, 0, 31);
    pal_next[6]  = make_pixel(10, 10, 10);
    pal_next[7]  = make_pixel(10, 10, 10);
    pal_next[8]  = make_pixel(31, 31, 0);
    pal_next[9]  = make_pixel(0, 31, 31);
    pal_next[10] = make_pixel(31, 0, 31);
    pal_next[11] = make_pixel(16, 16, 16);
    pal_next[12] = make_pixel(20, 5, 25);
    pal_next[13] = make_pixel(2, 0, 0);
    pal_next[14] = make_pixel(5, 25, 12);
    pal_next[15] = make_pixel(30, 30, 30);
    load_palette();
    // equal distance to entries 0 and 1, and to entries 6 and 11
    send_pair(make_pixel(1, 0, 0), make_pixel(13, 13, 13));
    // exact hits on duplicated entries
    send_pair(make_pixel(2, 0, 0), make_pixel(10, 10, 10));
    send_pair(make_pixel(31, 31, 31), make_pixel(30, 30, 30));
    send_pair(make_pixel(0, 31, 0), make_pixel(31, 0, 0));
    send_pair(make_pixel(0, 0, 31), make_pixel(31, 31, 0));
    send_pair(make_pixel(0, 31, 31), make_pixel(31, 0, 31));
    send_pair(make_pixel(20, 5, 25), make_pixel(5, 25, 12));
    send_pair(make_pixel(0, 0, 0), make_pixel(16, 16, 16));
    wait_idle();
    // writes above the last palette register must leave the palette alone
    write_reg(PalRegFirstUnused, '1);
    write_reg(PalRegLastUnused, pvq_pkg::CfgW'({$urandom(), $urandom()}));
    send_pair(make_pixel(31, 31, 31), make_pixel(1, 0, 0));
    send_pair(make_pixel(10, 10, 10), make_pixel(2, 0, 0));
    wait_idle();
  endtask

  task automatic test_random_traffic();
    pvq_pkg::pixel_t few [4];
    for (int ph = 0; ph < NumPhases; ph++) begin
      for (int j = 0; j < 4; j++) few[j] = pvq_pkg::pixel_t'($urandom());
      for (int k = 0; k < pvq_pkg::NumEntries; k++) begin
        case (ph % 3)
          0: pal_next[k] = pvq_pkg::pixel_t'($urandom());
          1: pal_next[k] = {coarse_level(), coarse_level(), coarse_level()};
          default: pal_next[k] = few[$urandom_range(0, 3)];
        endcase
      end
      load_palette();
      if ($urandom_range(0, 1))
        write_reg(pvq_pkg::CfgIdxW'($urandom_range(PalRegFirstUnused, PalRegLastUnused)),
                  pvq_pkg::CfgW'({$urandom(), $urandom()}));
      no_gaps = (ph == 2);
      for (int n = 0; n < PhaseItems; n++) send_pair(random_pixel(), random_pixel());
      wait_idle();
      no_gaps = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idx_if.ready <= 1'b0;
    end else if (no_gaps) begin
      idx_if.ready <= 1'b1;
    end else if (out_stall > 0) begin
      idx_if.ready <= 1'b0;
      out_stall--;
    end else begin
      idx_if.ready <= 1'b1;
      out_stall = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    logic [pvq_pkg::OutW-1:0] want;
    if (rst_ni && idx_if.valid && idx_if.ready) begin
      if (expected_indices_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %02h", idx_if.packed_indices));
      end else begin
        want = expected_indices_q.pop_front();
        if (idx_if.packed_indices !== want)
          report_mismatch($sformatf("packed_indices: got odd %0d even %0d, want odd %0d even %0d",
                                    idx_if.packed_indices[7:4], idx_if.packed_indices[3:0],
                                    want[7:4], want[3:0]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (idx_if.valid && idx_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= PalReg0;
    cfg_wdata_i       <= '0;
    pix_if.valid      <= 1'b0;
    pix_if.even_red   <= '0;
    pix_if.even_green <= '0;
    pix_if.even_blue  <= '0;
    pix_if.odd_red    <= '0;
    pix_if.odd_green  <= '0;
    pix_if.odd_blue   <= '0;
    mismatches        = 0;
    idle_cycles       = 0;
    out_stall         = 0;
    no_gaps           = 1'b0;
    for (int k = 0; k < pvq_pkg::NumEntries; k++) pal_model[k] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_palette();
    test_register_extremes();
    test_ties_and_duplicates();
    test_random_traffic();

    wait_idle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/pvq_pkg.sv
hdl/pvq_if.sv
hdl/pvq_cell.sv
hdl/palette_vector_quantizer.sv
tb/palette_vector_quantizer_tb.sv
